FILE: rtl/lmse_pkg.sv
package lmse_pkg;

    // Input operation codes
    localparam logic [1:0] OP_ROW   = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BRIGHTNESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERLAY_BRIGHTNESS = 2'd1;

    localparam int BRIGHT_W = 7;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd100;

    localparam int COLOR_W = 24;
    localparam int WORD_W  = 64;

    // SPI byte codes for one color bit
    localparam logic [7:0] BIT_ONE_CODE  = 8'hFC;
    localparam logic [7:0] BIT_ZERO_CODE = 8'hE0;

    // floor(p / 100) as (p * 5243) >> 19, exact for p below 32768
    localparam int PROD_W      = 15;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int QPROD_W     = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE1,
        ST_SCALE2,
        ST_WRITE,
        ST_PREAMBLE,
        ST_LED
    } lmse_state_t;

    typedef struct packed {
        logic       latch_in;
        logic       clear_ovl;
        logic       rd_en;
        logic       write_ovl;
        logic       load_word;
        logic       word_zero;
        logic       capture_led;
        logic [1:0] word_sel;
        logic       last;
        logic       row_advance;
    } lmse_cmd_t;

    typedef struct packed {
        logic out_free;
        logic row_zero;
    } lmse_status_t;

    function automatic logic [WORD_W-1:0] encode_word(input logic [COLOR_W-1:0] color,
                                                      input logic [1:0] sel);
        logic [7:0]        chan;
        logic [WORD_W-1:0] word;
        case (sel)
            2'd0:    chan = color[23:16];
            2'd1:    chan = color[15:8];
            default: chan = color[7:0];
        endcase
        for (int i = 0; i < 8; i++) begin
            word[WORD_W-1-8*i -: 8] = chan[7-i] ? BIT_ONE_CODE : BIT_ZERO_CODE;
        end
        return word;
    endfunction

endpackage

FILE: rtl/led_matrix_spi_frame_encoder.sv
// Row item: after accept, the color passes the input latch and two scaling
// stages, then one 64-bit word per cycle while m_ready holds: 3*COLS words,
// plus ceil(PREAMBLE_BYTES/8) zero words on the first row of a frame. The next
// item is taken the cycle after the last word loads.
// Pixel set scales the color, then does one store write; clear is done at accept.
// Reset (aresetn low, synchronous): idle, row 0, overlay empty, brightness 100.
module led_matrix_spi_frame_encoder
    import lmse_pkg::*;
#(
    parameter int ROWS           = 9,
    parameter int COLS           = 7,
    parameter int PREAMBLE_BYTES = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input item channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_operation,
    input  logic [7:0]             s_row_bits,
    input  logic [COLOR_W-1:0]     s_row_color,
    input  logic [3:0]             s_pixel_x,
    input  logic [3:0]             s_pixel_y,
    input  logic [COLOR_W-1:0]     s_pixel_color,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BRIGHT_W-1:0]    cfg_data,
    // result channel: one beat per SPI word
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [WORD_W-1:0]      m_spi_word,
    output logic                   m_last
);

    // Row and column index widths; the overlay store is addressed as {row, col}
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

    lmse_cmd_t        cmd;
    lmse_status_t     status;
    logic [COL_W-1:0] rd_col;

    // Controller: sequence the scaling pipeline, the preamble and the
    // per-LED word emission; hold intake while an item is in flight.
    lmse_ctrl #(
        .COLS           (COLS),
        .PREAMBLE_BYTES (PREAMBLE_BYTES),
        .COL_W          (COL_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd),
        .rd_col      (rd_col)
    );

    // Datapath: brightness registers, color scaler, overlay store with
    // valid bits, row counter, pending flag, bit encoder and output register.
    lmse_datapath #(
        .ROWS  (ROWS),
        .COLS  (COLS),
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_operation   (s_operation),
        .s_row_bits    (s_row_bits),
        .s_row_color   (s_row_color),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .s_pixel_color (s_pixel_color),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_spi_word    (m_spi_word),
        .m_last        (m_last),
        .cmd           (cmd),
        .rd_col        (rd_col),
        .status        (status)
    );

endmodule

FILE: rtl/lmse_ctrl.sv
module lmse_ctrl
    import lmse_pkg::*;
#(
    parameter int COLS           = 7,
    parameter int PREAMBLE_BYTES = 48,
    parameter int COL_W          = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [1:0]         s_operation,
    output logic               s_ready,
    input  lmse_status_t       status,
    output lmse_cmd_t          cmd,
    output logic [COL_W-1:0]   rd_col
);

    localparam int PRE_WORDS = (PREAMBLE_BYTES + 7) / 8;
    localparam int PRE_W     = (PRE_WORDS > 1) ? $clog2(PRE_WORDS + 1) : 1;

    lmse_state_t      state_reg, state_next;
    logic             is_row_reg, is_row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [1:0]       wsel_reg, wsel_next;
    logic [PRE_W-1:0] pre_reg, pre_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            is_row_reg <= 1'b0;
            col_reg    <= '0;
            wsel_reg   <= '0;
            pre_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            is_row_reg <= is_row_next;
            col_reg    <= col_next;
            wsel_reg   <= wsel_next;
            pre_reg    <= pre_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        is_row_next = is_row_reg;
        col_next    = col_reg;
        wsel_next   = wsel_reg;
        pre_next    = pre_reg;
        cmd         = '0;
        rd_col      = col_reg;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    col_next     = '0;
                    case (s_operation)
                        OP_ROW: begin
                            is_row_next = 1'b1;
                            state_next  = ST_SCALE1;
                        end
                        OP_PIXEL: begin
                            is_row_next = 1'b0;
                            state_next  = ST_SCALE1;
                        end
                        OP_CLEAR: cmd.clear_ovl = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_SCALE1: begin
                // fetch overlay entry of column 0 while the color scales
                cmd.rd_en  = is_row_reg;
                rd_col     = '0;
                state_next = ST_SCALE2;
            end
            ST_SCALE2: begin
                pre_next  = '0;
                wsel_next = '0;
                if (!is_row_reg) begin
                    state_next = ST_WRITE;
                end else if (status.row_zero && PRE_WORDS != 0) begin
                    state_next = ST_PREAMBLE;
                end else begin
                    state_next = ST_LED;
                end
            end
            ST_WRITE: begin
                cmd.write_ovl = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_PREAMBLE: begin
                if (status.out_free) begin
                    cmd.load_word = 1'b1;
                    cmd.word_zero = 1'b1;
                    pre_next      = pre_reg + 1'b1;
                    if (pre_reg == PRE_W'(PRE_WORDS - 1)) begin
                        state_next = ST_LED;
                    end
                end
            end
            ST_LED: begin
                cmd.word_sel = wsel_reg;
                rd_col       = COL_W'(col_reg + 1'b1);
                if (status.out_free) begin
                    cmd.load_word = 1'b1;
                    if (wsel_reg == 2'd0) begin
                        // latch this LED, then prefetch the next column
                        cmd.capture_led = 1'b1;
                        cmd.rd_en       = (col_reg != COL_W'(COLS - 1));
                    end
                    if (wsel_reg == 2'd2) begin
                        wsel_next = '0;
                        if (col_reg == COL_W'(COLS - 1)) begin
                            cmd.last        = 1'b1;
                            cmd.row_advance = 1'b1;
                            state_next      = ST_IDLE;
                        end else begin
                            col_next = COL_W'(col_reg + 1'b1);
                        end
                    end else begin
                        wsel_next = wsel_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/lmse_datapath.sv
module lmse_datapath
    import lmse_pkg::*;
#(
    parameter int ROWS  = 9,
    parameter int COLS  = 7,
    parameter int ROW_W = 4,
    parameter int COL_W = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             s_operation,
    input  logic [7:0]             s_row_bits,
    input  logic [COLOR_W-1:0]     s_row_color,
    input  logic [3:0]             s_pixel_x,
    input  logic [3:0]             s_pixel_y,
    input  logic [COLOR_W-1:0]     s_pixel_color,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BRIGHT_W-1:0]    cfg_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [WORD_W-1:0]      m_spi_word,
    output logic                   m_last,
    input  lmse_cmd_t              cmd,
    input  logic [COL_W-1:0]       rd_col,
    output lmse_status_t           status
);

    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [BRIGHT_W-1:0] frame_bright_reg, overlay_bright_reg;
    logic [7:0]          row_bits_reg;
    logic [COLOR_W-1:0]  color_in_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [ROW_W-1:0]    px_reg;
    logic [COL_W-1:0]    py_reg;
    logic [3:0]          px_clamp, py_clamp;

    logic [PROD_W-1:0]   prod_reg [3];
    logic [COLOR_W-1:0]  scaled_reg, scaled_next;

    logic [COLOR_W-1:0]  ovl_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] ovl_valid_reg;
    logic [COLOR_W-1:0]  rd_data_reg;
    logic                rd_valid_reg;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;

    logic [ROW_W-1:0]    row_reg;
    logic                pending_reg;

    logic [COLS-1:0]     col_bits;
    logic [COLOR_W-1:0]  led_comb, led_reg, led_src;

    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_spi_word_reg;
    logic                m_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bright_reg   <= BRIGHT_RESET;
            overlay_bright_reg <= BRIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_BRIGHTNESS:   frame_bright_reg   <= cfg_data;
                CFG_OVERLAY_BRIGHTNESS: overlay_bright_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign px_clamp = (s_pixel_x > 4'(ROWS - 1)) ? 4'(ROWS - 1) : s_pixel_x;
    assign py_clamp = (s_pixel_y > 4'(COLS - 1)) ? 4'(COLS - 1) : s_pixel_y;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            row_bits_reg <= s_row_bits;
            px_reg       <= ROW_W'(px_clamp);
            py_reg       <= COL_W'(py_clamp);
            if (s_operation == OP_ROW) begin
                color_in_reg <= s_row_color;
                bright_reg   <= frame_bright_reg;
            end else begin
                color_in_reg <= s_pixel_color;
                bright_reg   <= overlay_bright_reg;
            end
        end
    end

    // channel scaling: multiply, then divide by 100 through the reciprocal, saturating at 255
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            prod_reg[k] <= PROD_W'(color_in_reg[8*k +: 8]) * PROD_W'(bright_reg);
        end
        scaled_reg <= scaled_next;
    end

    always_comb begin
        logic [QPROD_W-1:0] qprod;
        logic [8:0]         quo;
        scaled_next = '0;
        for (int k = 0; k < 3; k++) begin
            qprod = QPROD_W'(prod_reg[k]) * QPROD_W'(RECIP_100);
            quo   = qprod[QPROD_W-1:RECIP_SHIFT];
            scaled_next[8*k +: 8] = quo[8] ? 8'hFF : quo[7:0];
        end
    end

    assign rd_addr = {row_reg, rd_col};
    assign wr_addr = {px_reg, py_reg};

    always_ff @(posedge aclk) begin
        if (cmd.write_ovl) begin
            ovl_mem[wr_addr] <= scaled_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= ovl_mem[rd_addr];
            rd_valid_reg <= ovl_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovl_valid_reg <= '0;
        end else if (cmd.clear_ovl) begin
            ovl_valid_reg <= '0;
        end else if (cmd.write_ovl) begin
            ovl_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            pending_reg <= 1'b0;
        end else begin
            if (cmd.write_ovl) begin
                pending_reg <= 1'b1;
            end
            if (cmd.row_advance) begin
                if (row_reg == ROW_W'(ROWS - 1)) begin
                    row_reg     <= '0;
                    pending_reg <= 1'b0;
                end else begin
                    row_reg <= row_reg + 1'b1;
                end
            end
        end
    end

    for (genvar i = 0; i < COLS; i++) begin : g_col_bits
        assign col_bits[i] = row_bits_reg[7-i];
    end

    always_comb begin
        led_comb = col_bits[rd_col - 1'b1] ? scaled_reg : '0;
        if (pending_reg && rd_valid_reg) begin
            led_comb = led_comb | rd_data_reg;
        end
    end

    assign led_src = cmd.capture_led ? led_comb : led_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture_led) begin
            led_reg <= led_comb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_word) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_word) begin
            m_spi_word_reg <= cmd.word_zero ? '0 : encode_word(led_src, cmd.word_sel);
            m_last_reg     <= cmd.last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_spi_word = m_spi_word_reg;
    assign m_last     = m_last_reg;

    assign status.out_free = !m_valid_reg || m_ready;
    assign status.row_zero = (row_reg == '0);

endmodule

FILE: tb/lmse_checker.sv
`timescale 1ns / 100ps

module lmse_checker
    import lmse_pkg::*;
#(
    parameter int ROWS           = 9,
    parameter int COLS           = 7,
    parameter int PREAMBLE_BYTES = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [1:0]             s_operation,
    input  logic [7:0]             s_row_bits,
    input  logic [COLOR_W-1:0]     s_row_color,
    input  logic [3:0]             s_pixel_x,
    input  logic [3:0]             s_pixel_y,
    input  logic [COLOR_W-1:0]     s_pixel_color,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BRIGHT_W-1:0]    cfg_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [WORD_W-1:0]      m_spi_word,
    input  logic                   m_last,
    output int                     mismatches,
    output int                     words_outstanding
);

    localparam int PREAMBLE_WORDS = (PREAMBLE_BYTES + 7) / 8;
    localparam int LEDS           = ROWS * COLS;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } spi_beat_t;

    logic [BRIGHT_W-1:0] frame_bright;
    logic [BRIGHT_W-1:0] ovl_bright;
    logic [COLOR_W-1:0]  ovl_color [LEDS];
    logic                ovl_pending;
    logic [3:0]          next_row;
    spi_beat_t           words_due [$];
    spi_beat_t           head;
    int                  fail_count = 0;
    int                  beat_no    = 0;

    assign mismatches = fail_count;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    // floor(c*b/100), saturating at full scale for brightness above 100
    function automatic logic [7:0] scale_chan(input logic [7:0] c,
                                              input logic [BRIGHT_W-1:0] b);
        int v;
        v = (int'(c) * int'(b)) / 100;
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function automatic logic [COLOR_W-1:0] scale_grb(input logic [COLOR_W-1:0] color,
                                                     input logic [BRIGHT_W-1:0] b);
        return {scale_chan(color[23:16], b), scale_chan(color[15:8], b),
                scale_chan(color[7:0], b)};
    endfunction

    function automatic logic [WORD_W-1:0] grb_word(input logic [COLOR_W-1:0] color,
                                                   input int w);
        logic [WORD_W-1:0] word;
        word = '0;
        for (int i = 0; i < 8; i++) begin
            word = {word[WORD_W-9:0], color[23 - 8*w - i] ? BIT_ONE_CODE : BIT_ZERO_CODE};
        end
        return word;
    endfunction

    task automatic advance_encoder(input logic [1:0]         op,
                                   input logic [7:0]         bits,
                                   input logic [COLOR_W-1:0] rcolor,
                                   input logic [3:0]         px,
                                   input logic [3:0]         py,
                                   input logic [COLOR_W-1:0] pcolor);
        int               x;
        int               y;
        int               r;
        logic [COLOR_W-1:0] lit;
        logic [COLOR_W-1:0] led;
        spi_beat_t        beat;
        case (op)
            OP_PIXEL: begin
                x = (px > ROWS - 1) ? ROWS - 1 : px;
                y = (py > COLS - 1) ? COLS - 1 : py;
                ovl_color[x*COLS + y] = scale_grb(pcolor, ovl_bright);
                ovl_pending = 1'b1;
            end
            OP_CLEAR: begin
                for (int i = 0; i < LEDS; i++) ovl_color[i] = '0;
            end
            OP_ROW: begin
                lit = scale_grb(rcolor, frame_bright);
                r   = (next_row >= ROWS) ? 0 : next_row;
                if (r == 0) begin
                    for (int p = 0; p < PREAMBLE_WORDS; p++) words_due.push_back('0);
                end
                for (int col = 0; col < COLS; col++) begin
                    led = bits[7-col] ? lit : '0;
                    if (ovl_pending) led = led | ovl_color[r*COLS + col];
                    for (int w = 0; w < 3; w++) begin
                        beat.word = grb_word(led, w);
                        beat.last = (col == COLS - 1) && (w == 2);
                        words_due.push_back(beat);
                    end
                end
                r++;
                if (r >= ROWS) begin
                    r           = 0;
                    ovl_pending = 1'b0;
                end
                next_row = r[3:0];
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_bright = BRIGHT_RESET;
            ovl_bright   = BRIGHT_RESET;
            for (int i = 0; i < LEDS; i++) ovl_color[i] = '0;
            ovl_pending  = 1'b0;
            next_row     = '0;
            words_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (words_due.size() == 0) begin
                    report_mismatch($sformatf("word %0d unexpected: %h last %b",
                                              beat_no, m_spi_word, m_last));
                end else begin
                    head = words_due.pop_front();
                    if (m_spi_word !== head.word)
                        report_mismatch($sformatf("word %0d spi_word %h, want %h",
                                                  beat_no, m_spi_word, head.word));
                    if (m_last !== head.last)
                        report_mismatch($sformatf("word %0d last %b, want %b",
                                                  beat_no, m_last, head.last));
                end
                beat_no++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_BRIGHTNESS:   frame_bright = cfg_data;
                    CFG_OVERLAY_BRIGHTNESS: ovl_bright   = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                advance_encoder(s_operation, s_row_bits, s_row_color,
                                s_pixel_x, s_pixel_y, s_pixel_color);
        end
        words_outstanding <= words_due.size();
    end

endmodule

FILE: tb/tb_led_matrix_spi_frame_encoder.sv
`timescale 1ns / 100ps

module tb_led_matrix_spi_frame_encoder;
    import lmse_pkg::*;

    localparam int ROWS           = 9;
    localparam int COLS           = 7;
    localparam int PREAMBLE_BYTES = 48;

    // Codes the block must ignore: the spare operation and the spare indexes
    localparam logic [1:0]             OP_UNUSED    = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    // A pixel set runs inside the block with no word to show for it,
    // so hold this many cycles after the last word before touching registers.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 30;
    // Cycles without any beat on any channel before the run is declared hung
    localparam int QUIET_LIMIT   = 4000;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic [1:0]             s_operation   = OP_ROW;
    logic [7:0]             s_row_bits    = '0;
    logic [COLOR_W-1:0]     s_row_color   = '0;
    logic [3:0]             s_pixel_x     = '0;
    logic [3:0]             s_pixel_y     = '0;
    logic [COLOR_W-1:0]     s_pixel_color = '0;
    logic                   cfg_valid     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = CFG_FRAME_BRIGHTNESS;
    logic [BRIGHT_W-1:0]    cfg_data      = '0;
    logic                   m_ready       = 1'b0;
    logic                   s_ready;
    logic                   cfg_ready;
    logic                   m_valid;
    logic [WORD_W-1:0]      m_spi_word;
    logic                   m_last;

    int mismatches;
    int words_outstanding;
    int src_idle    = 25;
    int sink_idle   = 57;
    int quiet_count = 0;

    always #5 aclk = ~aclk;

    led_matrix_spi_frame_encoder #(
        .ROWS          (ROWS),
        .COLS          (COLS),
        .PREAMBLE_BYTES(PREAMBLE_BYTES)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_row_bits   (s_row_bits),
        .s_row_color  (s_row_color),
        .s_pixel_x    (s_pixel_x),
        .s_pixel_y    (s_pixel_y),
        .s_pixel_color(s_pixel_color),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_spi_word   (m_spi_word),
        .m_last       (m_last)
    );

    lmse_checker #(
        .ROWS          (ROWS),
        .COLS          (COLS),
        .PREAMBLE_BYTES(PREAMBLE_BYTES)
    ) checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_row_bits       (s_row_bits),
        .s_row_color      (s_row_color),
        .s_pixel_x        (s_pixel_x),
        .s_pixel_y        (s_pixel_y),
        .s_pixel_color    (s_pixel_color),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_spi_word       (m_spi_word),
        .m_last           (m_last),
        .mismatches       (mismatches),
        .words_outstanding(words_outstanding)
    );

    // Throttle the word sink: drop ready in sink_idle cycles of a hundred
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    // Watchdog: advance on cycles with no beat anywhere, clear on any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one input beat after a random gap and hold it until accepted.
    // Valid stays high on return so a back-to-back beat needs no dip.
    task automatic send_item(input logic [1:0]         op,
                             input logic [7:0]         bits,
                             input logic [COLOR_W-1:0] rcolor,
                             input logic [3:0]         px,
                             input logic [3:0]         py,
                             input logic [COLOR_W-1:0] pcolor);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_row_bits    <= bits;
        s_row_color   <= rcolor;
        s_pixel_x     <= px;
        s_pixel_y     <= py;
        s_pixel_color <= pcolor;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_row(input logic [7:0] bits, input logic [COLOR_W-1:0] color);
        send_item(OP_ROW, bits, color, 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), COLOR_W'($urandom()));
    endtask

    task automatic send_pixel(input logic [3:0] px, input logic [3:0] py,
                              input logic [COLOR_W-1:0] color);
        send_item(OP_PIXEL, 8'($urandom_range(0, 255)), COLOR_W'($urandom()),
                  px, py, color);
    endtask

    // Stop offering items, then hold until every predicted word has drained
    // and the block has had time to finish any silent pixel or clear item.
    task automatic drain_words;
        s_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [BRIGHT_W-1:0]    data);
        drain_words();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly rows so frames keep wrapping, with pixel sets, clears and the
    // spare operation mixed in; spare-operation beats do not count.
    task automatic run_random(input int count);
        int done;
        int pick;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_row(8'($urandom_range(0, 255)), COLOR_W'($urandom()));
                done++;
            end else if (pick < 86) begin
                send_pixel(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                           COLOR_W'($urandom()));
                done++;
            end else if (pick < 93) begin
                send_item(OP_CLEAR, 8'($urandom_range(0, 255)), COLOR_W'($urandom()),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          COLOR_W'($urandom()));
                done++;
            end else begin
                send_item(OP_UNUSED, 8'($urandom_range(0, 255)), COLOR_W'($urandom()),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          COLOR_W'($urandom()));
            end
            // Now and then hold the sender until the sink has caught up
            if ($urandom_range(0, 39) == 0) drain_words();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Writes to the spare indexes must leave both brightness registers alone
        write_reg(CFG_SPARE_LO, 7'h7F);
        write_reg(CFG_SPARE_HI, 7'h00);

        // Directed frame at reset brightness. Column 7 of a full row is ignored.
        send_row(8'hFF, 24'hFFFFFF);
        send_row(8'h00, 24'hFFFFFF);
        send_row(8'hA5, 24'h123456);
        // Pixels set mid-frame: out-of-range coordinates clamp to the last LED,
        // the one in row 0 is already past and does not show in this frame
        send_pixel(4'hF, 4'hF, 24'hFFFFFF);
        send_pixel(4'h0, 4'h0, 24'h00FF00);
        send_pixel(4'd5, 4'd3, 24'h808080);
        send_item(OP_UNUSED, 8'hFF, 24'hFFFFFF, 4'hF, 4'hF, 24'hFFFFFF);
        send_row(8'h80, 24'h800000);
        send_row(8'h01, 24'h0000FF);
        send_row(8'h7F, 24'h00FF00);
        send_row(8'h55, 24'hFF0000);
        send_row(8'hFE, 24'h010101);
        send_row(8'h00, 24'h000000);
        // Pending cleared at frame end; set again and see it in the new frame
        send_pixel(4'h0, 4'h0, 24'h0000FF);
        send_row(8'h00, 24'h000000);
        // Clear empties the store but keeps pending and the row position
        send_item(OP_CLEAR, 8'hFF, 24'hFFFFFF, 4'hF, 4'hF, 24'hFFFFFF);
        send_row(8'hFF, 24'h0F0F0F);
        send_pixel(4'd2, 4'd1, 24'hFFFFFF);
        send_row(8'hC3, 24'hABCDEF);

        // Dark rows, saturating overlay
        write_reg(CFG_FRAME_BRIGHTNESS, 7'd0);
        write_reg(CFG_OVERLAY_BRIGHTNESS, 7'd127);
        run_random(60);

        // Saturating rows, dark overlay; swap the idling of the two sides
        write_reg(CFG_FRAME_BRIGHTNESS, 7'd127);
        write_reg(CFG_OVERLAY_BRIGHTNESS, 7'd0);
        src_idle  = 57;
        sink_idle = 25;
        run_random(60);

        // Mid-range rows, full overlay, no idling on either side
        write_reg(CFG_FRAME_BRIGHTNESS, BRIGHT_W'($urandom_range(1, 99)));
        write_reg(CFG_OVERLAY_BRIGHTNESS, 7'd100);
        src_idle  = 0;
        sink_idle = 0;
        run_random(60);

        // Drain everything, give the block a tail, then judge
        s_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: led_matrix_spi_frame_encoder.f
rtl/lmse_pkg.sv
rtl/lmse_ctrl.sv
rtl/lmse_datapath.sv
rtl/led_matrix_spi_frame_encoder.sv
tb/lmse_checker.sv
tb/tb_led_matrix_spi_frame_encoder.sv
